// ===== hdl/cttot_pkg.sv =====
// Shared types and constants for the charge to time-over-threshold block.
// No dependencies; imported by the divider and the top level.
package cttot_pkg;

    // default widths of the charge field and of the time fraction
    localparam int CHARGE_BITS_DEF = 20;
    localparam int FRAC_BITS_DEF   = 8;

    // fixed field widths
    localparam int TIME_W    = 30;
    localparam int CFG_W     = 20;
    localparam int CFG_IDX_W = 3;
    localparam int REG16_W   = 16;
    localparam int THRESH_W  = 20;

    // register reset values and the stand-in for a zero fall rate
    localparam logic [REG16_W-1:0] FALL_RATE_RST    = 16'd60;
    localparam logic [REG16_W-1:0] CLOCK_PERIOD_RST = 16'd2560;
    localparam logic [REG16_W-1:0] FALL_RATE_DEF    = 16'd60;

    // register indexes of the write port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RISE_TIME    = 3'd0,
        CFG_FALL_RATE    = 3'd1,
        CFG_THRESHOLD    = 3'd2,
        CFG_CLOCK_PERIOD = 3'd3,
        CFG_START_OFFSET = 3'd4
    } t_cfg_idx;

endpackage

// ===== hdl/charge_to_time_over_threshold_top.sv =====
// Charge to time-over-threshold front-end: start/stop clock edges, ToT and pile-up time.
// Depends on cttot_pkg and cttot_div.
// Words pass the input register, stage 1, the charge divider, stage 2, the period divider,
// stage 3 and the output register. Throughput: one word per cycle; a stalled output
// holds the whole pipeline. Reset (synchronous, active low) clears all valid bits
// and loads the register defaults; the block accepts words in the cycle after reset.
module charge_to_time_over_threshold_top #(
    parameter int CHARGE_BITS = cttot_pkg::CHARGE_BITS_DEF,
    parameter int FRAC_BITS   = cttot_pkg::FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration writes
    input  logic                           i_cfg_we,
    input  logic [cttot_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [cttot_pkg::CFG_W-1:0]    i_cfg_data,
    // input words
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [CHARGE_BITS-1:0]         i_charge,
    // result words
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [cttot_pkg::TIME_W-1:0]   o_tot_time,
    output logic [cttot_pkg::TIME_W-1:0]   o_start_time,
    output logic [cttot_pkg::TIME_W-1:0]   o_stop_time,
    output logic [cttot_pkg::TIME_W-1:0]   o_pileup_time,
    output logic                           o_below_threshold
);
    import cttot_pkg::*;

    localparam int CW  = (CHARGE_BITS > THRESH_W) ? CHARGE_BITS : THRESH_W;
    localparam int NW1 = CHARGE_BITS + REG16_W;
    localparam int DW1 = (CHARGE_BITS > REG16_W) ? CHARGE_BITS : REG16_W;
    localparam int EW  = (NW1 + 2 > 33) ? NW1 + 2 : 33;
    localparam int NW2 = 32;
    localparam int PW  = NW2 + REG16_W;
    localparam int LANES1 = 3;
    localparam logic [EW-1:0]   CLAMP   = EW'(64'h8000_0000);
    localparam logic [PW:0]     SAT_MAX = (PW+1)'({TIME_W{1'b1}});

    // configuration registers
    logic [REG16_W-1:0]  r_rise_time;
    logic [REG16_W-1:0]  r_fall_rate;
    logic [THRESH_W-1:0] r_threshold;
    logic [REG16_W-1:0]  r_clock_period;
    logic [REG16_W-1:0]  r_start_offset;

    logic                en;
    logic [REG16_W-1:0]  fa;
    logic [REG16_W-1:0]  per;

    // stage 0: input register
    logic                   r_s0_vld;
    logic [CHARGE_BITS-1:0] r_s0_charge;

    // stage 1: compare, multiply, numerators
    logic                       r_s1_vld;
    logic                       r_s1_below;
    logic [LANES1-1:0][NW1-1:0] r_s1_num;
    logic [LANES1-1:0][DW1-1:0] r_s1_den;

    logic                       d1_vld;
    logic                       d1_below;
    logic [LANES1-1:0][NW1-1:0] d1_quot;

    // stage 2: add offsets, clamp, pile-up saturation
    logic                       r_s2_vld;
    logic [TIME_W:0]            r_s2_side;
    logic [1:0][NW2-1:0]        r_s2_num;

    logic                       d2_vld;
    logic [TIME_W:0]            d2_side;
    logic [1:0][NW2-1:0]        d2_quot;

    // stage 3: quotient times period
    logic                       r_s3_vld;
    logic [TIME_W:0]            r_s3_side;
    logic [PW-1:0]              r_s3_start;
    logic [PW-1:0]              r_s3_stop;

    // stage 4: output register
    logic                       r_out_vld;
    logic [TIME_W-1:0]          r_tot;
    logic [TIME_W-1:0]          r_start;
    logic [TIME_W-1:0]          r_stop;
    logic [TIME_W-1:0]          r_pile;
    logic                       r_below;

    // advance the whole pipe unless a finished word waits
    assign en         = !r_out_vld || i_out_ready;
    assign o_in_ready = en;
    assign fa  = (r_fall_rate == '0) ? FALL_RATE_DEF : r_fall_rate;
    assign per = (r_clock_period == '0) ? REG16_W'(1) : r_clock_period;

    // register writes; unknown indexes drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rise_time    <= '0;
            r_fall_rate    <= FALL_RATE_RST;
            r_threshold    <= '0;
            r_clock_period <= CLOCK_PERIOD_RST;
            r_start_offset <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RISE_TIME:    r_rise_time    <= i_cfg_data[REG16_W-1:0];
                CFG_FALL_RATE:    r_fall_rate    <= i_cfg_data[REG16_W-1:0];
                CFG_THRESHOLD:    r_threshold    <= i_cfg_data[THRESH_W-1:0];
                CFG_CLOCK_PERIOD: r_clock_period <= i_cfg_data[REG16_W-1:0];
                CFG_START_OFFSET: r_start_offset <= i_cfg_data[REG16_W-1:0];
                default: ;
            endcase
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld  <= 1'b0;
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_s0_vld  <= i_in_valid;
            r_s1_vld  <= r_s0_vld;
            r_s2_vld  <= d1_vld;
            r_s3_vld  <= d2_vld;
            r_out_vld <= r_s3_vld;
        end
    end

    // stage 1: below-threshold substitution, rise*threshold, shifted numerators
    logic [CW-1:0]          chg_w;
    logic [CW-1:0]          thr_w;
    logic                   n_below;
    logic [CHARGE_BITS-1:0] q;
    logic [CHARGE_BITS-1:0] qt;

    always_comb begin
        chg_w   = CW'(r_s0_charge);
        thr_w   = CW'(r_threshold);
        n_below = (chg_w <= thr_w);
        q       = n_below ? CHARGE_BITS'(1) : r_s0_charge;
        qt      = n_below ? CHARGE_BITS'(1) : thr_w[CHARGE_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_below  <= n_below;
            r_s1_num[0] <= NW1'(r_rise_time) * NW1'(qt);
            r_s1_num[1] <= NW1'(q - qt) << FRAC_BITS;
            r_s1_num[2] <= NW1'(r_s0_charge) << FRAC_BITS;
            r_s1_den[0] <= DW1'(q);
            r_s1_den[1] <= DW1'(fa);
            r_s1_den[2] <= DW1'(fa);
            r_s0_charge <= i_charge;
        end
    end

    cttot_div #(
        .NW    (NW1),
        .DW    (DW1),
        .LANES (LANES1),
        .SW    (1)
    ) u_div_charge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s1_vld),
        .i_side  (r_s1_below),
        .i_num   (r_s1_num),
        .i_den   (r_s1_den),
        .o_valid (d1_vld),
        .o_side  (d1_below),
        .o_quot  (d1_quot)
    );

    // stage 2: crossing times, clamped so later saturation stays exact
    logic [EW-1:0] t1;
    logic [EW-1:0] t2;
    logic [EW-1:0] pile;

    always_comb begin
        t1   = EW'(d1_quot[0]) + EW'(r_start_offset);
        t2   = EW'(d1_quot[1]) + EW'(r_start_offset) + EW'(r_rise_time);
        pile = EW'(d1_quot[2]) + EW'(r_rise_time);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_num[0] <= (t1 >= CLAMP) ? NW2'(CLAMP) : t1[NW2-1:0];
            r_s2_num[1] <= (t2 >= CLAMP) ? NW2'(CLAMP) : t2[NW2-1:0];
            r_s2_side[TIME_W] <= d1_below;
            r_s2_side[TIME_W-1:0] <= (pile > EW'({TIME_W{1'b1}})) ?
                                     {TIME_W{1'b1}} : pile[TIME_W-1:0];
        end
    end

    cttot_div #(
        .NW    (NW2),
        .DW    (REG16_W),
        .LANES (2),
        .SW    (TIME_W + 1)
    ) u_div_period (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s2_vld),
        .i_side  (r_s2_side),
        .i_num   (r_s2_num),
        .i_den   ({per, per}),
        .o_valid (d2_vld),
        .o_side  (d2_side),
        .o_quot  (d2_quot)
    );

    // stage 3: floor(t/P)*P
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3_start <= PW'(d2_quot[0]) * PW'(per);
            r_s3_stop  <= PW'(d2_quot[1]) * PW'(per);
            r_s3_side  <= d2_side;
        end
    end

    // stage 4: next edge, difference, saturation
    logic [PW:0] e_start;
    logic [PW:0] e_stop;
    logic [PW:0] e_tot;

    always_comb begin
        e_start = (PW+1)'(r_s3_start) + (PW+1)'(per);
        e_stop  = (PW+1)'(r_s3_stop) + (PW+1)'(per);
        e_tot   = (e_stop >= e_start) ? e_stop - e_start : '0;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tot   <= (e_tot > SAT_MAX) ? {TIME_W{1'b1}} : e_tot[TIME_W-1:0];
            r_start <= (e_start > SAT_MAX) ? {TIME_W{1'b1}} : e_start[TIME_W-1:0];
            r_stop  <= (e_stop > SAT_MAX) ? {TIME_W{1'b1}} : e_stop[TIME_W-1:0];
            r_pile  <= r_s3_side[TIME_W-1:0];
            r_below <= r_s3_side[TIME_W];
        end
    end

    assign o_out_valid       = r_out_vld;
    assign o_tot_time        = r_tot;
    assign o_start_time      = r_start;
    assign o_stop_time       = r_stop;
    assign o_pileup_time     = r_pile;
    assign o_below_threshold = r_below;

    // a hit under threshold never shows time over threshold
    a_below_no_tot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_below_threshold |-> o_tot_time == '0)
        else $error("below-threshold word with nonzero ToT");

    // the first edge lies at least one period out
    a_start_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_start_time != '0)
        else $error("start edge at zero");

    // dead time never undercuts the rise time
    a_pile_ge_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_pileup_time >= TIME_W'(r_rise_time))
        else $error("pile-up time below rise time");

endmodule

// ===== hdl/cttot_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage, several lanes.
// Uses cttot_pkg by convention; no other modules.
module cttot_div #(
    parameter int NW    = 36,
    parameter int DW    = 20,
    parameter int LANES = 1,
    parameter int SW    = 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [SW-1:0]                i_side,
    input  logic [LANES-1:0][NW-1:0]     i_num,
    input  logic [LANES-1:0][DW-1:0]     i_den,
    output logic                         o_valid,
    output logic [SW-1:0]                o_side,
    output logic [LANES-1:0][NW-1:0]     o_quot
);
    import cttot_pkg::*;

    localparam int AW = DW + NW;

    logic [LANES-1:0][AW-1:0] r_acc  [NW];
    logic [LANES-1:0][DW-1:0] r_den  [NW];
    logic [SW-1:0]            r_side [NW];
    logic                     r_vld  [NW];

    for (genvar s = 0; s < NW; s++) begin : g_stage
        logic [LANES-1:0][AW-1:0] a_in;
        logic [LANES-1:0][DW-1:0] d_in;
        logic [SW-1:0]            s_in;
        logic                     v_in;
        logic [LANES-1:0][AW-1:0] n_acc;

        // pick up the previous stage, or the input port for the first one
        if (s == 0) begin : g_first
            always_comb begin
                for (int l = 0; l < LANES; l++) begin
                    a_in[l] = {{DW{1'b0}}, i_num[l]};
                end
                d_in = i_den;
                s_in = i_side;
                v_in = i_valid;
            end
        end else begin : g_next
            always_comb begin
                a_in = r_acc[s-1];
                d_in = r_den[s-1];
                s_in = r_side[s-1];
                v_in = r_vld[s-1];
            end
        end

        // shift in one numerator bit, subtract the divisor when it fits
        always_comb begin
            logic [DW:0] v_top;
            logic [DW:0] v_diff;
            v_top  = '0;
            v_diff = '0;
            for (int l = 0; l < LANES; l++) begin
                v_top  = a_in[l][AW-1:NW-1];
                v_diff = v_top - {1'b0, d_in[l]};
                if (v_top >= {1'b0, d_in[l]}) begin
                    n_acc[l] = {v_diff[DW-1:0], a_in[l][NW-2:0], 1'b1};
                end else begin
                    n_acc[l] = {v_top[DW-1:0], a_in[l][NW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_acc[s]  <= n_acc;
                r_den[s]  <= d_in;
                r_side[s] <= s_in;
            end
        end
    end

    // quotient sits in the low bits of the last accumulator
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            o_quot[l] = r_acc[NW-1][l][NW-1:0];
        end
    end
    assign o_valid = r_vld[NW-1];
    assign o_side  = r_side[NW-1];

endmodule
